// File: design/tcff_pkg.sv
// ----------------------------------------------------------------------------
// tcff_pkg
// Shared types and codes for the torus cluster flood fill unit: item field
// widths, function codes, neighbor codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tcff_pkg;

  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 7;
  localparam int COORD_SPAN = 1 << COORD_W;
  localparam int SIZE_W     = 15;

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CHECK,
    ST_NBR,
    ST_POP,
    ST_FETCH
  } tcff_state_t;

endpackage

// File: design/tcff_in_if.sv
// ----------------------------------------------------------------------------
// tcff_in_if
// Input channel: one word per item (function, site coordinates, value).
// ----------------------------------------------------------------------------
interface tcff_in_if;
  import tcff_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic               site_value;

  modport source (output valid, output func, output x_coord, output y_coord,
                  output site_value, input ready);
  modport sink   (input valid, input func, input x_coord, input y_coord,
                  input site_value, output ready);
endinterface

// File: design/tcff_out_if.sv
// ----------------------------------------------------------------------------
// tcff_out_if
// Result channel: one word per item (cluster size, overflow flag).
// ----------------------------------------------------------------------------
interface tcff_out_if;
  import tcff_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] fill_size;
  logic              stack_overflow;

  modport source (output valid, output fill_size, output stack_overflow,
                  input ready);
  modport sink   (input valid, input fill_size, input stack_overflow,
                  output ready);
endinterface

// File: design/torus_cluster_flood_fill_unit.sv
// ----------------------------------------------------------------------------
// torus_cluster_flood_fill_unit
// Writes, clears and flood-fill searches on a torus lattice held in RAM.
// Write and unused codes: the result is registered and offered in the cycle after the item is taken.
// Clear: result in the cycle after, then a sweep over all LATTICE_SIDE^2 sites clears the visited map only.
// Search: a flood fill from the start site through marked, unvisited sites,
// with a stack held in RAM; one map RAM read per cycle.
// Reset: a sweep over all LATTICE_SIDE^2 sites clears both maps; no item taken.
// ----------------------------------------------------------------------------
module torus_cluster_flood_fill_unit #(
  parameter int LATTICE_SIDE = 128,
  parameter int STACK_DEPTH  = 65536
) (
  input logic      clk,
  input logic      rst_n,
  tcff_in_if.sink  in_chan,
  tcff_out_if.source out_chan
);
  import tcff_pkg::*;

  localparam int CW    = $clog2(LATTICE_SIDE);
  localparam int SITES = LATTICE_SIDE * LATTICE_SIDE;
  localparam int SW    = $clog2(SITES);
  localparam int EW    = 2 * CW;
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int PW    = $clog2(STACK_DEPTH + 1);

  function automatic logic [SW-1:0] site_idx(input logic [CW-1:0] r,
                                             input logic [CW-1:0] c);
    return SW'(SW'(r) * SW'(LATTICE_SIDE) + SW'(c));
  endfunction

  logic [CW-1:0] coord_lut [COORD_SPAN];

  for (genvar i = 0; i < COORD_SPAN; i++) begin : g_lut
    assign coord_lut[i] = CW'(i % LATTICE_SIDE);
  end

  tcff_state_t       state_r, state_nxt;
  logic [PW-1:0]     sp_r, sp_nxt;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     row_r, row_nxt, col_r, col_nxt;
  logic [CW-1:0]     pend_row_r, pend_row_nxt, pend_col_r, pend_col_nxt;
  logic [1:0]        nb_idx_r, nb_idx_nxt;
  logic [SW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              clr_occ_r, clr_occ_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic          in_ready, in_take;
  logic [CW-1:0] in_row, in_col;
  logic [1:0]    nb_sel;
  logic [CW-1:0] nb_row, nb_col;
  logic [CW-1:0] fetch_row, fetch_col;
  logic          live;

  logic          occ_we, occ_wd, occ_rd;
  logic [SW-1:0] occ_wa, map_ra;
  logic          vis_we, vis_wd, vis_rd;
  logic [SW-1:0] vis_wa;
  logic          stk_we;
  logic [AW-1:0] stk_wa, stk_ra;
  logic [EW-1:0] stk_wd, stk_rd;

  tcff_ram #(.DEPTH(SITES), .WIDTH(1)) u_occ (
    .clk(clk), .wr_en(occ_we), .wr_addr(occ_wa), .wr_data(occ_wd),
    .rd_addr(map_ra), .rd_data(occ_rd)
  );

  tcff_ram #(.DEPTH(SITES), .WIDTH(1)) u_vis (
    .clk(clk), .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
    .rd_addr(map_ra), .rd_data(vis_rd)
  );

  tcff_ram #(.DEPTH(STACK_DEPTH), .WIDTH(EW)) u_stk (
    .clk(clk), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
    .rd_addr(stk_ra), .rd_data(stk_rd)
  );

  assign in_row    = coord_lut[in_chan.x_coord];
  assign in_col    = coord_lut[in_chan.y_coord];
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_take   = in_ready && in_chan.valid;
  assign fetch_row = stk_rd[EW-1:CW];
  assign fetch_col = stk_rd[CW-1:0];
  assign live      = occ_rd && !vis_rd;
  assign nb_sel    = (state_r == ST_CHECK) ? NB_UP : 2'(nb_idx_r + 2'd1);

  always_comb begin
    nb_row = row_r;
    nb_col = col_r;
    case (nb_sel)
      NB_UP:    nb_row = (row_r == '0) ? CW'(LATTICE_SIDE - 1) : CW'(row_r - 1'b1);
      NB_DOWN:  nb_row = (row_r == CW'(LATTICE_SIDE - 1)) ? '0 : CW'(row_r + 1'b1);
      NB_LEFT:  nb_col = (col_r == '0) ? CW'(LATTICE_SIDE - 1) : CW'(col_r - 1'b1);
      NB_RIGHT: nb_col = (col_r == CW'(LATTICE_SIDE - 1)) ? '0 : CW'(col_r + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      sp_r        <= '0;
      clr_addr_r  <= '0;
      clr_occ_r   <= 1'b1;
      out_valid_r <= 1'b0;
      nb_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_occ_r   <= clr_occ_nxt;
      out_valid_r <= out_valid_nxt;
      nb_idx_r    <= nb_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    ovf_r      <= ovf_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    out_size_r <= out_size_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    pend_row_nxt  = pend_row_r;
    pend_col_nxt  = pend_col_r;
    nb_idx_nxt    = nb_idx_r;
    clr_addr_nxt  = clr_addr_r;
    clr_occ_nxt   = clr_occ_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_size_nxt  = out_size_r;
    out_ovf_nxt   = out_ovf_r;

    occ_we = 1'b0;
    occ_wa = clr_addr_r;
    occ_wd = 1'b0;
    vis_we = 1'b0;
    vis_wa = clr_addr_r;
    vis_wd = 1'b0;
    stk_we = 1'b0;
    stk_wa = sp_r[AW-1:0];
    stk_wd = {pend_row_r, pend_col_r};
    stk_ra = AW'(sp_r - 1'b1);
    map_ra = site_idx(nb_row, nb_col);

    case (state_r)
      ST_CLR: begin
        vis_we = 1'b1;
        occ_we = clr_occ_r;
        clr_addr_nxt = SW'(clr_addr_r + 1'b1);
        if (clr_addr_r == SW'(SITES - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        map_ra = site_idx(in_row, in_col);
        if (in_take) begin
          row_nxt = in_row;
          col_nxt = in_col;
          if (in_chan.func == FUNC_SEARCH) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            sp_nxt    = '0;
            state_nxt = ST_CHECK;
          end else begin
            out_valid_nxt = 1'b1;
            out_size_nxt  = '0;
            out_ovf_nxt   = 1'b0;
            if (in_chan.func == FUNC_WRITE) begin
              occ_we = 1'b1;
              occ_wa = site_idx(in_row, in_col);
              occ_wd = in_chan.site_value;
            end else if (in_chan.func == FUNC_CLEAR) begin
              clr_addr_nxt = '0;
              clr_occ_nxt  = 1'b0;
              state_nxt    = ST_CLR;
            end
          end
        end
      end
      ST_CHECK: begin
        if (live) begin
          vis_we       = 1'b1;
          vis_wa       = site_idx(row_r, col_r);
          vis_wd       = 1'b1;
          cnt_nxt      = (cnt_r == SIZE_MAX) ? cnt_r : SIZE_W'(cnt_r + 1'b1);
          pend_row_nxt = nb_row;
          pend_col_nxt = nb_col;
          nb_idx_nxt   = NB_UP;
          state_nxt    = ST_NBR;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_NBR: begin
        if (live) begin
          if (sp_r >= PW'(STACK_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            stk_we = 1'b1;
            sp_nxt = PW'(sp_r + 1'b1);
          end
        end
        if (nb_idx_r == NB_RIGHT) begin
          state_nxt = ST_POP;
        end else begin
          pend_row_nxt = nb_row;
          pend_col_nxt = nb_col;
          nb_idx_nxt   = nb_sel;
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          out_valid_nxt = 1'b1;
          out_size_nxt  = cnt_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end else begin
          sp_nxt    = PW'(sp_r - 1'b1);
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        map_ra    = site_idx(fetch_row, fetch_col);
        row_nxt   = fetch_row;
        col_nxt   = fetch_col;
        state_nxt = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.fill_size      = out_size_r;
  assign out_chan.stack_overflow = out_ovf_r;

endmodule

// File: design/tcff_ram.sv
// ----------------------------------------------------------------------------
// tcff_ram
// Simple dual-port synchronous RAM: one write and one registered read per
// cycle; read data appears in the cycle after its address.
// ----------------------------------------------------------------------------
module tcff_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/tcff_checker.sv
// ----------------------------------------------------------------------------
// tcff_checker
// Port-level checks for the torus cluster flood fill unit, bound to the top.
// ----------------------------------------------------------------------------
module tcff_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [tcff_pkg::FUNC_W-1:0] in_func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tcff_pkg::SIZE_W-1:0] out_fill_size,
  input logic                        out_stack_overflow
);
  import tcff_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input word taken while result stalled");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func != FUNC_SEARCH |=>
      out_valid && out_fill_size == '0 && !out_stack_overflow)
    else $error("non-search word gave a nonzero result");

  a_ovf_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_overflow |-> out_fill_size != '0)
    else $error("overflow flagged on an empty search");

endmodule

bind torus_cluster_flood_fill_unit tcff_checker u_tcff_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .in_func            (in_chan.func),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_fill_size      (out_chan.fill_size),
  .out_stack_overflow (out_chan.stack_overflow)
);
